/* src/wsd_pkg.sv */
package wsd_pkg;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;
  localparam logic [6:0]  LEN16_CODE        = 7'd126;
  localparam logic [6:0]  LEN64_CODE        = 7'd127;
  localparam logic [7:0]  MASK_BIT          = 8'h80;
  localparam logic [6:0]  LEN7_MASK         = 7'h7F;
  localparam logic [3:0]  OPCODE_MASK       = 4'hF;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [3:0]  frame_opcode;
    logic [15:0] byte_index;
    logic        last;
    logic        empty_frame;
    logic        truncated;
    logic [63:0] declared_length;
  } wsd_result_t;

endpackage

/* src/websocket_frame_deframer_unit.sv */
// Frame deframer for a stream of received bytes in the standard framing layout.
// Input channel: one stream byte per beat on rx_byte with in_valid and in_ready.
// Output channel: one payload byte per beat with out_valid and out_ready, carrying
// the unmasked byte, the frame opcode, its position, the last and empty-frame flags,
// the truncation flag and the declared length. Header bytes and discarded payload
// bytes produce no output beat; a frame that keeps no bytes produces one marker.
// The configuration register max_payload is written with cfg_wr_en and cfg_wr_data
// and should only be changed while the block is idle.
// An accepted byte is held in an input register, decoded against the frame state and
// captured in the output register. Throughput is one byte per cycle while the output
// register is empty or draining, set by the single decode stage.
// When the receiver stalls, the output register holds its beat and the input
// register can still take one more byte; bytes that give no output keep flowing.
// Reset clears the frame state, empties both registers and sets max_payload to 65535.
module websocket_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [3:0]  frame_opcode,
  output logic [15:0] byte_index,
  output logic        last,
  output logic        empty_frame,
  output logic        truncated,
  output logic [63:0] declared_length
);
  import wsd_pkg::*;

  logic        [15:0] max_payload;
  logic               s1_valid;
  logic        [7:0]  s1_byte;
  logic               s1_adv;
  logic               res_valid;
  wsd_result_t        res;
  wsd_result_t        out_reg;

  assign s1_adv   = s1_valid && (!res_valid || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s1_valid),
    .step        (s1_adv),
    .rx_byte     (s1_byte),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_reg <= res;
    end
  end

  assign data_byte       = out_reg.data_byte;
  assign frame_opcode    = out_reg.frame_opcode;
  assign byte_index      = out_reg.byte_index;
  assign last            = out_reg.last;
  assign empty_frame     = out_reg.empty_frame;
  assign truncated       = out_reg.truncated;
  assign declared_length = out_reg.declared_length;

endmodule

/* src/wsd_parser.sv */
module wsd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [15:0]          max_payload,
  output logic                 res_valid,
  output wsd_pkg::wsd_result_t res
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [3:0]  op_reg, op_reg_next;
  logic        mask_flag, mask_flag_next;
  logic [2:0]  ext_count, ext_count_next;
  logic [63:0] length_reg, length_reg_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] remaining, remaining_next;
  logic [15:0] kept_count, kept_count_next;
  logic        produce;

  always_comb begin
    logic [6:0]  len7;
    logic        hdr_done;
    logic [63:0] rem_dec;
    logic [15:0] limit;
    logic [16:0] idx_inc;
    logic        is_last;
    logic [7:0]  key_byte;
    phase_next      = phase;
    op_reg_next     = op_reg;
    mask_flag_next  = mask_flag;
    ext_count_next  = ext_count;
    length_reg_next = length_reg;
    mask_key_next   = mask_key;
    remaining_next  = remaining;
    kept_count_next = kept_count;
    produce         = 1'b0;
    hdr_done        = 1'b0;
    len7            = rx_byte[6:0] & LEN7_MASK;
    rem_dec         = remaining - 64'd1;
    is_last         = 1'b0;
    limit           = 16'd0;
    idx_inc         = 17'd0;
    key_byte        = 8'd0;
    res.data_byte   = 8'd0;
    res.byte_index  = 16'd0;
    res.last        = 1'b0;
    res.empty_frame = 1'b0;
    case (phase)
      PH_HDR0: begin
        op_reg_next = rx_byte[3:0] & OPCODE_MASK;
        phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_flag_next = (rx_byte & MASK_BIT) != 8'd0;
        if (len7 == LEN16_CODE) begin
          length_reg_next = 64'd0;
          ext_count_next  = 3'd1;
          phase_next      = PH_EXT;
        end else if (len7 == LEN64_CODE) begin
          length_reg_next = 64'd0;
          ext_count_next  = 3'd7;
          phase_next      = PH_EXT;
        end else begin
          length_reg_next = {57'd0, len7};
          if (mask_flag_next) begin
            ext_count_next = 3'd3;
            mask_key_next  = 32'd0;
            phase_next     = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXT: begin
        length_reg_next = {length_reg[55:0], rx_byte};
        if (ext_count != 3'd0) begin
          ext_count_next = ext_count - 3'd1;
        end else if (mask_flag) begin
          ext_count_next = 3'd3;
          mask_key_next  = 32'd0;
          phase_next     = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (ext_count != 3'd0) begin
          ext_count_next = ext_count - 3'd1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        case (kept_count[1:0])
          2'd0:    key_byte = mask_key[31:24];
          2'd1:    key_byte = mask_key[23:16];
          2'd2:    key_byte = mask_key[15:8];
          default: key_byte = mask_key[7:0];
        endcase
        limit = ((length_reg[63:16] == 48'd0) && (length_reg[15:0] < max_payload)) ?
                length_reg[15:0] : max_payload;
        idx_inc         = {1'b0, kept_count} + 17'd1;
        is_last         = idx_inc >= {1'b0, limit};
        remaining_next  = rem_dec;
        kept_count_next = idx_inc[15:0];
        produce         = 1'b1;
        res.data_byte   = mask_flag ? (rx_byte ^ key_byte) : rx_byte;
        res.byte_index  = kept_count;
        res.last        = is_last;
        if (is_last) begin
          phase_next = (rem_dec != 64'd0) ? PH_SKIP : PH_HDR0;
        end else if (rem_dec == 64'd0) begin
          phase_next = PH_HDR0;
        end
      end
      PH_SKIP: begin
        if (remaining != 64'd0) begin
          remaining_next = rem_dec;
        end
        if (remaining_next == 64'd0) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase
    if (hdr_done) begin
      remaining_next  = length_reg_next;
      kept_count_next = 16'd0;
      if ((length_reg_next == 64'd0) || (max_payload == 16'd0)) begin
        produce         = 1'b1;
        res.last        = 1'b1;
        res.empty_frame = 1'b1;
        phase_next      = (length_reg_next != 64'd0) ? PH_SKIP : PH_HDR0;
      end else begin
        phase_next = PH_DATA;
      end
    end
    res.frame_opcode    = op_reg_next;
    res.declared_length = length_reg_next;
    res.truncated       = (length_reg_next[63:16] != 48'd0) ||
                          (length_reg_next[15:0] > max_payload);
  end

  assign res_valid = in_valid && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      op_reg     <= 4'd0;
      mask_flag  <= 1'b0;
      ext_count  <= 3'd0;
      length_reg <= 64'd0;
      mask_key   <= 32'd0;
      remaining  <= 64'd0;
      kept_count <= 16'd0;
    end else if (step) begin
      phase      <= phase_next;
      op_reg     <= op_reg_next;
      mask_flag  <= mask_flag_next;
      ext_count  <= ext_count_next;
      length_reg <= length_reg_next;
      mask_key   <= mask_key_next;
      remaining  <= remaining_next;
      kept_count <= kept_count_next;
    end
  end

endmodule

/* src/wsd_checker.sv */
module wsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data_byte,
  input logic [15:0] byte_index,
  input logic        last,
  input logic        empty_frame,
  input logic        truncated,
  input logic [63:0] declared_length
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(byte_index))
    else $error("stalled output beat changed");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_frame |-> last && (data_byte == 8'd0) && (byte_index == 16'd0))
    else $error("empty-frame marker malformed");

  a_marker_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_frame && !truncated |-> declared_length == 64'd0)
    else $error("marker without truncation for a frame with payload");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_frame |-> declared_length > {48'd0, byte_index})
    else $error("payload byte index beyond declared length");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (.*);
